// ===== sv/cseg_pkg.sv =====
// Shared types, constants and helpers for the contour cell segmenter.
`timescale 1ns / 1ps

package cseg_pkg;

    localparam int HEIGHT_W = 16;
    localparam int LVL_W    = 18;   // internal level width, room for the ceiling overshoot
    localparam int POS_W    = 19;
    localparam int NUM_W    = 20;   // ten times a 16-bit height difference
    localparam int QUO_W    = 17;
    localparam int SEG_W    = 6;
    localparam int MAX_SEGS = 32;

    typedef logic signed [HEIGHT_W-1:0] height_t;
    typedef logic signed [LVL_W-1:0]    lvl_t;

    // Level below every reachable start: opens each sweep
    localparam lvl_t LVL_FLOOR = -lvl_t'(65536);

    // Configuration register indexes
    localparam logic [1:0] REG_CONTOUR_STEP = 2'd0;
    localparam logic [1:0] REG_MAJOR_STEP   = 2'd1;
    localparam logic [1:0] REG_MIN_VALID    = 2'd2;

    typedef enum logic [3:0] {
        DIV_CEIL  = 4'b0001,
        DIV_FRAC0 = 4'b0010,
        DIV_FRAC1 = 4'b0100,
        DIV_MAJOR = 4'b1000
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    edge_skip;
        logic    edge_adv;
        logic    enum_step;
        logic    div_go;
        div_op_t div_op;
        logic    lvl_init;
        logic    lvl_adv;
        logic    seg_add;
        logic    pair_clr;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic edge_last;
        logic enum_end;
        logic div_done;
        logic has_next;
        logic seg_none;
        logic pair_more;
        logic out_free;
        logic out_last;
    } sts_t;

    // Index of the n-th set bit of a four-bit mask
    function automatic logic [1:0] nth_set(input logic [3:0] mask, input logic [1:0] n);
        logic [1:0] seen;
        logic [1:0] idx;
        seen = 2'd0;
        idx  = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                if (seen == n) begin
                    idx = 2'(i);
                end
                seen = seen + 2'd1;
            end
        end
        return idx;
    endfunction

endpackage

// ===== sv/cseg_div.sv =====
// Restoring divider, one quotient bit per cycle, with preloadable remainder.
`timescale 1ns / 1ps

module cseg_div
    import cseg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] init_rem,
    input  logic [QUO_W-1:0] dividend,
    input  logic [NUM_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient,
    output logic [NUM_W-1:0] remainder
);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] dvd_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [NUM_W-1:0] dsr_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [NUM_W:0]   trial;
    logic             fits;

    always_comb begin
        trial    = {rem_reg, dvd_reg[QUO_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? NUM_W'(trial - {1'b0, dsr_reg}) : trial[NUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(QUO_W);
                rem_reg  <= init_rem;
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/cseg_dp.sv =====
// Datapath: config, edge bounds, level sweep, fraction and major checks, result register.
`timescale 1ns / 1ps

module cseg_dp
    import cseg_pkg::*;
#(
    parameter int MAX_CROSSINGS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic [HEIGHT_W-1:0]  s_height_c0,
    input  logic [HEIGHT_W-1:0]  s_height_c1,
    input  logic [HEIGHT_W-1:0]  s_height_c2,
    input  logic [HEIGHT_W-1:0]  s_height_c3,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [HEIGHT_W-1:0]  m_level,
    output logic [POS_W-1:0]     m_start_pos,
    output logic [POS_W-1:0]     m_end_pos,
    output logic                 m_is_major,
    output logic                 m_last,
    output logic                 m_overflow
);

    localparam int CNT_W = $clog2(MAX_CROSSINGS + 1);

    // configuration
    logic [12:0] step_reg;
    logic [14:0] major_reg;
    height_t     minv_reg;

    // per cell
    height_t          h_reg [4];
    logic [3:0]       valid_reg;
    lvl_t             start_reg [4];
    lvl_t             end_reg [4];
    logic [1:0]       edge_reg;
    logic [CNT_W-1:0] xcount_reg;
    lvl_t             hh_reg;
    logic             ovf_reg;
    lvl_t             lvl_reg;
    logic [1:0]       pair_reg;
    logic [SEG_W-1:0] seg_total_reg;
    logic [SEG_W-1:0] seg_idx_reg;
    div_op_t          op_reg;
    logic [POS_W-1:0] spos_reg;
    logic [POS_W-1:0] epos_reg;
    logic             maj_reg;

    // result register
    logic                m_valid_reg;
    logic [HEIGHT_W-1:0] m_level_reg;
    logic [POS_W-1:0]    m_spos_reg;
    logic [POS_W-1:0]    m_epos_reg;
    logic                m_major_reg;
    logic                m_last_reg;
    logic                m_ovf_reg;

    logic [12:0] step_eff;
    logic [14:0] major_eff;
    lvl_t        step_l;

    always_comb begin
        step_eff  = (step_reg == 13'd0) ? 13'd1 : step_reg;
        major_eff = (major_reg == 15'd0) ? 15'd1 : major_reg;
        step_l    = lvl_t'({1'b0, step_eff});
    end

    // edge under scan
    height_t ea, eb;
    lvl_t    lo_l, hi_l;
    logic    edge_ok;

    always_comb begin
        ea      = h_reg[edge_reg];
        eb      = h_reg[edge_reg + 2'd1];
        lo_l    = (ea < eb) ? lvl_t'(ea) : lvl_t'(eb);
        hi_l    = (ea < eb) ? lvl_t'(eb) : lvl_t'(ea);
        edge_ok = !(ea < minv_reg) && !(eb < minv_reg) && (ea != eb) && !ovf_reg;
    end

    // level sweep: active edges at the current level and the next level
    logic [3:0] mask;
    logic [1:0] npairs;
    lvl_t       lvl_plus;
    lvl_t       cand [4];
    logic [3:0] cand_v;
    lvl_t       next_lvl;
    logic       has_next;

    always_comb begin
        lvl_plus = lvl_reg + step_l;
        for (int k = 0; k < 4; k++) begin
            mask[k]   = valid_reg[k] && (start_reg[k] <= lvl_reg) && (lvl_reg < end_reg[k]);
            cand_v[k] = 1'b0;
            cand[k]   = start_reg[k];
            if (valid_reg[k] && (start_reg[k] > lvl_reg) && (start_reg[k] < end_reg[k])) begin
                cand_v[k] = 1'b1;
            end else if (valid_reg[k] && (start_reg[k] <= lvl_reg) && (lvl_plus < end_reg[k])) begin
                cand_v[k] = 1'b1;
                cand[k]   = lvl_plus;
            end
        end
        npairs   = 2'(({2'b0, mask[0]} + {2'b0, mask[1]} + {2'b0, mask[2]}
                       + {2'b0, mask[3]}) >> 1);
        has_next = 1'b0;
        next_lvl = lvl_reg;
        for (int k = 0; k < 4; k++) begin
            if (cand_v[k] && (!has_next || cand[k] < next_lvl)) begin
                has_next = 1'b1;
                next_lvl = cand[k];
            end
        end
    end

    // divider operands
    logic [1:0]       sel_edge;
    height_t          fa, fb;
    logic [16:0]      up_d, dn_d, span;
    logic [NUM_W-1:0] num, den;
    logic [16:0]      lo_abs, lvl_abs;
    logic [NUM_W-1:0] d_init, d_dsr;
    logic [QUO_W-1:0] d_dvd;
    logic [QUO_W-1:0] d_quo;
    logic [NUM_W-1:0] d_rem;
    logic             d_done;
    logic             frac1;

    always_comb begin
        frac1    = (cmd.div_go && cmd.div_op == DIV_FRAC1) || (!cmd.div_go && op_reg == DIV_FRAC1);
        sel_edge = nth_set(mask, {pair_reg[0], frac1});
        fa       = h_reg[sel_edge];
        fb       = h_reg[sel_edge + 2'd1];
        up_d     = 17'(lvl_reg - lvl_t'(fa));
        dn_d     = 17'(lvl_t'(fa) - lvl_reg);
        span     = (fb > fa) ? 17'(lvl_t'(fb) - lvl_t'(fa)) : 17'(lvl_t'(fa) - lvl_t'(fb));
        den      = NUM_W'({span, 3'b000}) + NUM_W'({span, 1'b0});
        if (fb > fa) begin
            num = NUM_W'({up_d, 3'b000}) + NUM_W'({up_d, 1'b0}) + NUM_W'(1);
        end else begin
            num = NUM_W'({dn_d, 3'b000}) + NUM_W'({dn_d, 1'b0}) - NUM_W'(1);
        end
        lo_abs  = (lo_l < 0) ? 17'(-lo_l) : 17'(lo_l);
        lvl_abs = (lvl_reg < 0) ? 17'(-lvl_reg) : 17'(lvl_reg);
        d_init  = '0;
        d_dvd   = '0;
        d_dsr   = NUM_W'(step_eff);
        case (cmd.div_op)
            DIV_CEIL: begin
                d_dvd = lo_abs;
            end
            DIV_FRAC0, DIV_FRAC1: begin
                d_init = num;
                d_dsr  = den;
            end
            DIV_MAJOR: begin
                d_dvd = lvl_abs;
                d_dsr = NUM_W'(major_eff);
            end
            default: begin
                d_dvd = lo_abs;
            end
        endcase
    end

    cseg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_go),
        .init_rem  (d_init),
        .dividend  (d_dvd),
        .divisor   (d_dsr),
        .done      (d_done),
        .quotient  (d_quo),
        .remainder (d_rem)
    );

    // divider results
    logic [12:0]      ceil_r;
    lvl_t             ceil_start;
    logic [QUO_W:0]   q_inc;
    logic [1:0]       pos_edge;
    logic [POS_W-1:0] pos;

    always_comb begin
        ceil_r = d_rem[12:0];
        if (lo_l < 0) begin
            ceil_start = lo_l + lvl_t'({1'b0, ceil_r});
        end else if (ceil_r == 13'd0) begin
            ceil_start = lo_l;
        end else begin
            ceil_start = lo_l + step_l - lvl_t'({1'b0, ceil_r});
        end
        // the finishing fraction belongs to the edge of the running pass
        pos_edge = nth_set(mask, {pair_reg[0], op_reg == DIV_FRAC1});
        q_inc    = {1'b0, d_quo} + (QUO_W+1)'(1);
        pos      = {1'b0, pos_edge, 16'b0} + POS_W'(q_inc[QUO_W:1]);
    end

    // enumeration of one edge's levels into the crossing budget
    logic hh_lt_hi, xfull, enum_end;

    always_comb begin
        hh_lt_hi = hh_reg < hi_l;
        xfull    = xcount_reg == CNT_W'(MAX_CROSSINGS);
        enum_end = !hh_lt_hi || xfull;
    end

    logic [SEG_W-1:0] seg_lim;
    logic             out_free, out_last;

    always_comb begin
        seg_lim  = (seg_total_reg > SEG_W'(MAX_SEGS)) ? SEG_W'(MAX_SEGS) : seg_total_reg;
        out_free = !m_valid_reg || m_ready;
        out_last = seg_idx_reg == seg_lim - SEG_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= 13'd10;
            major_reg     <= 15'd50;
            minv_reg      <= -height_t'(32000);
            valid_reg     <= '0;
            ovf_reg       <= 1'b0;
            xcount_reg    <= '0;
            edge_reg      <= 2'd0;
            seg_total_reg <= '0;
            seg_idx_reg   <= '0;
            pair_reg      <= 2'd0;
            op_reg        <= DIV_CEIL;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CONTOUR_STEP: step_reg  <= cfg_data[12:0];
                    REG_MAJOR_STEP:   major_reg <= cfg_data[14:0];
                    REG_MIN_VALID:    minv_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                h_reg[0]      <= s_height_c0;
                h_reg[1]      <= s_height_c1;
                h_reg[2]      <= s_height_c2;
                h_reg[3]      <= s_height_c3;
                valid_reg     <= '0;
                ovf_reg       <= 1'b0;
                xcount_reg    <= '0;
                edge_reg      <= 2'd0;
                seg_total_reg <= '0;
            end
            if (cmd.edge_skip) begin
                valid_reg[edge_reg] <= 1'b0;
            end
            if (cmd.edge_adv) begin
                edge_reg <= edge_reg + 2'd1;
            end
            if (cmd.enum_step) begin
                if (enum_end) begin
                    end_reg[edge_reg]   <= hh_reg;
                    valid_reg[edge_reg] <= 1'b1;
                    if (hh_lt_hi) begin
                        ovf_reg <= 1'b1;
                    end
                end else begin
                    xcount_reg <= xcount_reg + CNT_W'(1);
                    hh_reg     <= hh_reg + step_l;
                end
            end
            if (cmd.div_go) begin
                op_reg <= cmd.div_op;
            end
            if (d_done) begin
                case (op_reg)
                    DIV_CEIL: begin
                        start_reg[edge_reg] <= ceil_start;
                        hh_reg              <= ceil_start;
                    end
                    DIV_FRAC0: spos_reg <= pos;
                    DIV_FRAC1: epos_reg <= pos;
                    DIV_MAJOR: maj_reg  <= d_rem == '0;
                    default: ;
                endcase
            end
            if (cmd.lvl_init) begin
                lvl_reg     <= LVL_FLOOR;
                seg_idx_reg <= '0;
            end
            if (cmd.lvl_adv) begin
                lvl_reg <= next_lvl;
            end
            if (cmd.seg_add && seg_total_reg <= SEG_W'(MAX_SEGS)) begin
                seg_total_reg <= seg_total_reg + SEG_W'(npairs);
            end
            if (cmd.pair_clr) begin
                pair_reg <= 2'd0;
            end
            if (cmd.out_load) begin
                pair_reg    <= pair_reg + 2'd1;
                seg_idx_reg <= seg_idx_reg + SEG_W'(1);
                m_valid_reg <= 1'b1;
                m_level_reg <= lvl_reg[HEIGHT_W-1:0];
                m_spos_reg  <= spos_reg;
                m_epos_reg  <= epos_reg;
                m_major_reg <= maj_reg;
                m_last_reg  <= out_last;
                m_ovf_reg   <= ovf_reg || (seg_total_reg > SEG_W'(MAX_SEGS));
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.edge_ok   = edge_ok;
        sts.edge_last = edge_reg == 2'd3;
        sts.enum_end  = enum_end;
        sts.div_done  = d_done;
        sts.has_next  = has_next;
        sts.seg_none  = seg_total_reg == '0;
        sts.pair_more = pair_reg < npairs;
        sts.out_free  = out_free;
        sts.out_last  = out_last;
    end

    assign m_valid     = m_valid_reg;
    assign m_level     = m_level_reg;
    assign m_start_pos = m_spos_reg;
    assign m_end_pos   = m_epos_reg;
    assign m_is_major  = m_major_reg;
    assign m_last      = m_last_reg;
    assign m_overflow  = m_ovf_reg;

endmodule

// ===== sv/cseg_ctrl.sv =====
// Controller: sequences edge scan, segment count sweep and segment output sweep.
`timescale 1ns / 1ps

module cseg_ctrl
    import cseg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_ECHECK = 13'b0000000000010,
        ST_ECEIL  = 13'b0000000000100,
        ST_EENUM  = 13'b0000000001000,
        ST_ENEXT  = 13'b0000000010000,
        ST_CADV   = 13'b0000000100000,
        ST_CADD   = 13'b0000001000000,
        ST_MADV   = 13'b0000010000000,
        ST_MPAIR  = 13'b0000100000000,
        ST_MD0    = 13'b0001000000000,
        ST_MD1    = 13'b0010000000000,
        ST_MMAJ   = 13'b0100000000000,
        ST_MOUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = DIV_CEIL;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ECHECK;
                end
            end
            ST_ECHECK: begin
                if (sts.edge_ok) begin
                    cmd.div_go = 1'b1;
                    state_next = ST_ECEIL;
                end else begin
                    cmd.edge_skip = 1'b1;
                    state_next    = ST_ENEXT;
                end
            end
            ST_ECEIL: begin
                if (sts.div_done) begin
                    state_next = ST_EENUM;
                end
            end
            ST_EENUM: begin
                cmd.enum_step = 1'b1;
                if (sts.enum_end) begin
                    state_next = ST_ENEXT;
                end
            end
            ST_ENEXT: begin
                if (sts.edge_last) begin
                    cmd.lvl_init = 1'b1;
                    state_next   = ST_CADV;
                end else begin
                    cmd.edge_adv = 1'b1;
                    state_next   = ST_ECHECK;
                end
            end
            ST_CADV: begin
                if (sts.has_next) begin
                    cmd.lvl_adv = 1'b1;
                    state_next  = ST_CADD;
                end else begin
                    cmd.lvl_init = 1'b1;
                    state_next   = sts.seg_none ? ST_IDLE : ST_MADV;
                end
            end
            ST_CADD: begin
                cmd.seg_add = 1'b1;
                state_next  = ST_CADV;
            end
            ST_MADV: begin
                if (sts.has_next) begin
                    cmd.lvl_adv  = 1'b1;
                    cmd.pair_clr = 1'b1;
                    state_next   = ST_MPAIR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MPAIR: begin
                if (sts.pair_more) begin
                    cmd.div_go = 1'b1;
                    cmd.div_op = DIV_FRAC0;
                    state_next = ST_MD0;
                end else begin
                    state_next = ST_MADV;
                end
            end
            ST_MD0: begin
                if (sts.div_done) begin
                    cmd.div_go = 1'b1;
                    cmd.div_op = DIV_FRAC1;
                    state_next = ST_MD1;
                end
            end
            ST_MD1: begin
                if (sts.div_done) begin
                    cmd.div_go = 1'b1;
                    cmd.div_op = DIV_MAJOR;
                    state_next = ST_MMAJ;
                end
            end
            ST_MMAJ: begin
                if (sts.div_done) begin
                    state_next = ST_MOUT;
                end
            end
            ST_MOUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.out_last ? ST_IDLE : ST_MPAIR;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

endmodule

// ===== sv/contour_cell_segmenter_top.sv =====
// Top level of the contour cell segmenter: controller, datapath and ports.
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Moves
// s_        s_valid/s_ready, s_height_c0..c3        in         one cell item
// m_        m_valid/m_ready, m_level .. m_overflow  out        one segment item
// cfg_      cfg_valid/cfg_ready, cfg_index/cfg_data in         one register write
//
// Flow: one cell at a time, accepted only while idle. A valid edge takes a check
// step, the level ceiling in the shared serial divider (17 quotient bits, then done),
// the enumeration of its kept crossings, a closing step and an advance; a skipped
// edge takes a check and an advance. The count sweep takes an advance and an add
// per occupied level. Each segment takes three divider passes (two fractions, one
// major-level remainder) plus a pair step and an output step that waits for a free
// output; each occupied level adds an advance and a pair check.
// Reset is synchronous, active low, and clears control state and loads register
// defaults. A stalled result holds in the output register; the controller waits
// only when a second result is ready.

module contour_cell_segmenter_top
    import cseg_pkg::*;
#(
    parameter int MAX_CROSSINGS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [HEIGHT_W-1:0] s_height_c0,
    input  logic [HEIGHT_W-1:0] s_height_c1,
    input  logic [HEIGHT_W-1:0] s_height_c2,
    input  logic [HEIGHT_W-1:0] s_height_c3,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HEIGHT_W-1:0] m_level,
    output logic [POS_W-1:0]    m_start_pos,
    output logic [POS_W-1:0]    m_end_pos,
    output logic                m_is_major,
    output logic                m_last,
    output logic                m_overflow,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // Registers are always writable: accept every write at once
    assign cfg_ready = 1'b1;

    cseg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cseg_dp #(
        .MAX_CROSSINGS (MAX_CROSSINGS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_height_c0 (s_height_c0),
        .s_height_c1 (s_height_c1),
        .s_height_c2 (s_height_c2),
        .s_height_c3 (s_height_c3),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level     (m_level),
        .m_start_pos (m_start_pos),
        .m_end_pos   (m_end_pos),
        .m_is_major  (m_is_major),
        .m_last      (m_last),
        .m_overflow  (m_overflow)
    );

endmodule
